>>> sv/llr_pkg.sv
// Shared types, constants and helper functions for the line reprojection residual block.
package llr_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_W      = 32;
   localparam int STORE_DEPTH = 24;
   localparam int ADDR_W      = 5;
   localparam int EXP_W       = 6;
   localparam int LANES       = 6;
   localparam int POINT_COMPS = 8;
   localparam int VCOUNT_W    = 11;
   localparam int VCTR_W      = 10;
   localparam int MAX_VIEWS   = 1024;
   localparam int CSR_ADDR_W  = 5;

   // register indexes on the csr port
   localparam logic [2:0] REG_LINE_PARAM_0 = 3'd0;
   localparam logic [2:0] REG_LINE_PARAM_1 = 3'd1;
   localparam logic [2:0] REG_LINE_PARAM_2 = 3'd2;
   localparam logic [2:0] REG_LINE_PARAM_3 = 3'd3;
   localparam logic [2:0] REG_VIEW_COUNT   = 3'd4;

   // item kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_ROW  = 1'b1;

   typedef logic signed [WORD_W-1:0] q_type;
   typedef logic signed [63:0]       wide_type;

   typedef struct packed {
      logic             start;
      logic [EXP_W-1:0] shift;
      logic [31:0]      dvsr;
   } div_req_type;

   typedef struct packed {
      logic  done;
      q_type quo;
   } div_rsp_type;

   function automatic q_type sat32(input wide_type v);
      q_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] mag64(input wide_type v);
      logic [63:0] u;
      u = v;
      return u[63] ? (~u + 64'd1) : u;
   endfunction

endpackage

>>> sv/llr_if.sv
// Valid/ready channel interfaces for row and load items and for residual results.
interface llr_req_if import llr_pkg::*; ();
   logic  valid;
   logic  ready;
   logic  req_type;
   logic [ADDR_W-1:0] index;
   q_type coef_0;
   q_type coef_1;
   q_type coef_2;
   q_type coef_3;
   q_type coef_4;
   q_type coef_5;
   q_type first_x;
   q_type first_y;
   q_type second_x;
   q_type second_y;

   modport source(output valid, req_type, index, coef_0, coef_1, coef_2, coef_3, coef_4,
                  coef_5, first_x, first_y, second_x, second_y, input ready);
   modport sink(input valid, req_type, index, coef_0, coef_1, coef_2, coef_3, coef_4,
                coef_5, first_x, first_y, second_x, second_y, output ready);
endinterface

interface llr_rsp_if import llr_pkg::*; ();
   logic  valid;
   logic  ready;
   q_type dist_first;
   q_type dist_second;
   logic  degenerate;
   logic  last_view;

   modport source(output valid, dist_first, dist_second, degenerate, last_view, input ready);
   modport sink(input valid, dist_first, dist_second, degenerate, last_view, output ready);
endinterface

>>> sv/llr_lane.sv
// One Pluecker lane: cross term, saturation and product with the row coefficient.
module llr_lane import llr_pkg::*; (
   input  logic     clock,
   input  q_type    x1,
   input  q_type    y1,
   input  q_type    x2,
   input  q_type    y2,
   input  q_type    coef,
   output wide_type term
);
   wide_type p1_ff, p2_ff, term_ff;
   q_type    l_ff;
   wide_type p1_in, p2_in, term_in;

   assign p1_in   = x1 * y1;
   assign p2_in   = x2 * y2;
   assign term_in = l_ff * coef;

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      l_ff    <= sat32((p1_ff >>> FRAC_BITS) - (p2_ff >>> FRAC_BITS));
      term_ff <= term_in >>> FRAC_BITS;
   end

   assign term = term_ff;
endmodule

>>> sv/llr_merge.sv
// Registered two-level adder tree over the six lane terms.
module llr_merge import llr_pkg::*; (
   input  logic     clock,
   input  wide_type term [LANES],
   output wide_type sum
);
   wide_type pair_ff [3];
   wide_type sum_ff;

   always_ff @(posedge clock) begin
      pair_ff[0] <= term[0] + term[1];
      pair_ff[1] <= term[2] + term[3];
      pair_ff[2] <= term[4] + term[5];
      sum_ff     <= pair_ff[0] + pair_ff[1] + pair_ff[2];
   end

   assign sum = sum_ff;
endmodule

>>> sv/llr_div.sv
// Restoring divider: saturated |num| * 2^shift / dvsr with sign, one quotient bit a cycle.
module llr_div import llr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   input  wide_type    num,
   output div_rsp_type rsp
);
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_CHECK = 2'd1;
   localparam logic [1:0] PH_RUN   = 2'd2;

   logic [1:0]   phase_ff;
   logic [4:0]   cnt_ff;
   logic         neg_ff, sat_ff, done_ff;
   logic [127:0] d_ff;
   logic [63:0]  rem_ff, dvs_ff;
   logic [31:0]  q_ff, dvsr_ff;
   q_type        quo_ff;
   logic [31:0]  q_in;

   assign q_in = (rem_ff >= dvs_ff) ? {q_ff[30:0], 1'b1} : {q_ff[30:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= (phase_ff == PH_RUN) && (cnt_ff == 5'd31);
         case (phase_ff)
            PH_IDLE: begin
               if (req.start) begin
                  phase_ff <= PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_ff <= PH_RUN;
               cnt_ff   <= '0;
            end
            PH_RUN: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  phase_ff <= PH_IDLE;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         PH_IDLE: begin
            neg_ff  <= num[63];
            d_ff    <= {64'd0, mag64(num)} << req.shift;
            dvsr_ff <= req.dvsr;
         end
         PH_CHECK: begin
            sat_ff <= d_ff >= ({96'd0, dvsr_ff} << 31);
            rem_ff <= d_ff[63:0];
            dvs_ff <= {1'b0, dvsr_ff, 31'd0};
            q_ff   <= '0;
         end
         PH_RUN: begin
            if (rem_ff >= dvs_ff) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            dvs_ff <= dvs_ff >> 1;
            q_ff   <= q_in;
            if (cnt_ff == 5'd31) begin
               if (sat_ff) begin
                  quo_ff <= neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  quo_ff <= neg_ff ? -q_in : q_in;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
endmodule

>>> sv/line_reprojection_residual.sv
// Top level of the line reprojection residual block.
//
//  channel | direction | handshake         | transfer carries
//  req_if  | in        | valid/ready       | store load word, or one view row
//  rsp_if  | out       | valid/ready       | two distances, degenerate, last_view
//  csr_*   | in/out    | APB, pready high  | line parameters, view count
//
// One item at a time. Load items and ignored items are taken without leaving idle.
// Rows 0/1 stream the 24 store words through the point multiplier, then pass the
// six-lane Pluecker/dot pipeline and its adder tree. Row 2 adds 0..33 scaling and
// 0..30 normalising shifts, 2 squaring steps, a 32-step square root and a divide;
// when both normalised magnitudes are zero it skips to the degenerate result.
// Synchronous active-high reset clears control state; the word store has no reset.
// A finished result waits in the output register; a new item is taken meanwhile, and
// only a row-2 item that is done before the previous result leaves stalls in its last step.
module line_reprojection_residual import llr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   llr_req_if.sink               req_if,
   llr_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PTS  = 4'd1;
   localparam logic [3:0] ST_PLK  = 4'd2;
   localparam logic [3:0] ST_SCL  = 4'd3;
   localparam logic [3:0] ST_NRM  = 4'd4;
   localparam logic [3:0] ST_SQ   = 4'd5;
   localparam logic [3:0] ST_ROOT = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   localparam logic [2:0]  PLK_LAT  = 3'd5;   // lanes (3) + adder tree (2)
   localparam logic [4:0]  LAST_WORD = 5'(STORE_DEPTH - 1);

   // ---------------- configuration ----------------
   q_type                param_ff [4];
   logic [VCOUNT_W-1:0]  vcount_ff;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            param_ff[i] <= '0;
         end
         vcount_ff <= VCOUNT_W'(1);
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_LINE_PARAM_0: param_ff[0] <= csr_pwdata;
            REG_LINE_PARAM_1: param_ff[1] <= csr_pwdata;
            REG_LINE_PARAM_2: param_ff[2] <= csr_pwdata;
            REG_LINE_PARAM_3: param_ff[3] <= csr_pwdata;
            REG_VIEW_COUNT:   vcount_ff   <= csr_pwdata[VCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_LINE_PARAM_0: csr_prdata = param_ff[0];
         REG_LINE_PARAM_1: csr_prdata = param_ff[1];
         REG_LINE_PARAM_2: csr_prdata = param_ff[2];
         REG_LINE_PARAM_3: csr_prdata = param_ff[3];
         REG_VIEW_COUNT:   csr_prdata = {{(32-VCOUNT_W){1'b0}}, vcount_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- control ----------------
   logic [3:0] state_ff;
   logic [4:0] cnt_ff;
   logic       req_xfer, rsp_xfer;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign rsp_xfer     = rsp_if.valid && rsp_if.ready;

   // item registers
   logic [1:0] row_ff;
   q_type      coef_ff [LANES];
   q_type      pt_ff   [4];

   // back-projection word store
   logic [WORD_W-1:0] ap_store [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (req_xfer && req_if.req_type == REQ_LOAD && req_if.index <= LAST_WORD) begin
         ap_store[req_if.index] <= req_if.coef_0;
      end
   end

   // ---------------- point stream: A = w0 + pa*w1 + pb*w2 ----------------
   logic       iss_act_ff;
   logic [4:0] iss_addr_ff;
   logic [1:0] iss_j_ff;
   logic [2:0] iss_c_ff;
   q_type      rd_ff;
   logic       rv_ff, mv_ff;
   logic [1:0] rj_ff, mj_ff;
   logic [2:0] rc_ff, mc_ff;
   wide_type   mval_ff, acc_ff, prod_in, acc_in;
   q_type      par;
   q_type      pt_a_ff [POINT_COMPS];

   assign par     = param_ff[{rc_ff[2], rj_ff[1]}];
   assign prod_in = rd_ff * par;
   assign acc_in  = acc_ff + mval_ff;

   always_ff @(posedge clock) begin
      if (iss_act_ff) begin
         rd_ff <= ap_store[iss_addr_ff];
      end
      rj_ff   <= iss_j_ff;
      rc_ff   <= iss_c_ff;
      mj_ff   <= rj_ff;
      mc_ff   <= rc_ff;
      mval_ff <= (rj_ff == 2'd0) ? 64'(rd_ff) : (prod_in >>> FRAC_BITS);
      if (mv_ff) begin
         case (mj_ff)
            2'd0:    acc_ff <= mval_ff;
            2'd1:    acc_ff <= acc_in;
            default: pt_a_ff[mc_ff] <= sat32(acc_in);
         endcase
      end
   end

   // ---------------- Pluecker lanes and merge ----------------
   wide_type term [LANES];
   wide_type lsum;
   q_type    la [4];
   q_type    lb [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         la[i] = pt_a_ff[i];
         lb[i] = pt_a_ff[4+i];
      end
   end

   llr_lane u_lane0 (.clock, .x1(la[1]), .y1(lb[2]), .x2(la[2]), .y2(lb[1]),
                     .coef(coef_ff[0]), .term(term[0]));
   llr_lane u_lane1 (.clock, .x1(la[2]), .y1(lb[0]), .x2(la[0]), .y2(lb[2]),
                     .coef(coef_ff[1]), .term(term[1]));
   llr_lane u_lane2 (.clock, .x1(la[0]), .y1(lb[1]), .x2(la[1]), .y2(lb[0]),
                     .coef(coef_ff[2]), .term(term[2]));
   llr_lane u_lane3 (.clock, .x1(lb[3]), .y1(la[0]), .x2(la[3]), .y2(lb[0]),
                     .coef(coef_ff[3]), .term(term[3]));
   llr_lane u_lane4 (.clock, .x1(lb[3]), .y1(la[1]), .x2(la[3]), .y2(lb[1]),
                     .coef(coef_ff[4]), .term(term[4]));
   llr_lane u_lane5 (.clock, .x1(lb[3]), .y1(la[2]), .x2(la[3]), .y2(lb[2]),
                     .coef(coef_ff[5]), .term(term[5]));

   llr_merge u_merge (.clock, .term, .sum(lsum));

   // ---------------- normalise, root, divide ----------------
   wide_type          partial_ff [2];
   wide_type          sc_a_ff, sc_b_ff, sc_c_ff;
   logic [63:0]       m_ff, m_in;
   logic [63:0]       mag_a, mag_b;
   logic [31:0]       ma_ff, mb_ff;
   logic [EXP_W-1:0]  e_ff;
   logic              deg_ff, last_ff;
   logic [VCTR_W-1:0] vctr_ff;
   logic [VCOUNT_W-1:0] limit;
   logic [VCOUNT_W-1:0] vnext;
   logic [63:0]       sq1_ff, sq2_ff, rad_ff, root_ff, bit_ff, trial;
   wide_type          px1_ff, py1_ff, px2_ff, py2_ff;
   wide_type          num_ff [2];
   q_type             a_q, b_q;
   div_req_type       div_req;
   div_rsp_type       div_rsp [2];
   logic              div_start_ff;
   q_type             dist1_ff, dist2_ff;
   logic              rsp_valid_ff, rsp_deg_ff, rsp_last_ff;

   assign a_q   = sc_a_ff[31:0];
   assign b_q   = sc_b_ff[31:0];
   assign mag_a = mag64(sc_a_ff);
   assign mag_b = mag64(sc_b_ff);
   assign trial = root_ff + bit_ff;
   assign vnext = {1'b0, vctr_ff} + VCOUNT_W'(1);

   always_comb begin
      if (vcount_ff == '0) begin
         limit = VCOUNT_W'(1);
      end else if (vcount_ff > VCOUNT_W'(MAX_VIEWS)) begin
         limit = VCOUNT_W'(MAX_VIEWS);
      end else begin
         limit = vcount_ff;
      end
   end

   always_comb begin
      m_in = mag64(partial_ff[0]);
      if (mag64(partial_ff[1]) > m_in) begin
         m_in = mag64(partial_ff[1]);
      end
      if (mag64(lsum) > m_in) begin
         m_in = mag64(lsum);
      end
   end

   assign div_req.start = div_start_ff;
   assign div_req.shift = e_ff;
   assign div_req.dvsr  = root_ff[31:0];

   llr_div u_div0 (.clock, .reset, .req(div_req), .num(num_ff[0]), .rsp(div_rsp[0]));
   llr_div u_div1 (.clock, .reset, .req(div_req), .num(num_ff[1]), .rsp(div_rsp[1]));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         iss_act_ff   <= 1'b0;
         rv_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         partial_ff[0] <= '0;
         partial_ff[1] <= '0;
         vctr_ff      <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_ROOT) && (cnt_ff == 5'd31);
         rv_ff        <= iss_act_ff;
         mv_ff        <= rv_ff;
         // a new result loads only when the output register is free or leaving
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer && req_if.req_type == REQ_ROW && req_if.index <= 5'd2) begin
                  state_ff    <= ST_PTS;
                  iss_act_ff  <= 1'b1;
                  iss_addr_ff <= '0;
                  iss_j_ff    <= '0;
                  iss_c_ff    <= '0;
               end
            end
            ST_PTS: begin
               if (iss_act_ff) begin
                  iss_addr_ff <= iss_addr_ff + 5'd1;
                  iss_j_ff    <= (iss_j_ff == 2'd2) ? 2'd0 : iss_j_ff + 2'd1;
                  if (iss_j_ff == 2'd2) begin
                     iss_c_ff <= iss_c_ff + 3'd1;
                  end
                  if (iss_addr_ff == LAST_WORD) begin
                     iss_act_ff <= 1'b0;
                  end
               end
               if (mv_ff && mj_ff == 2'd2 && mc_ff == 3'(POINT_COMPS - 1)) begin
                  state_ff <= ST_PLK;
                  cnt_ff   <= '0;
               end
            end
            ST_PLK: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff[2:0] == PLK_LAT) begin
                  if (row_ff != 2'd2) begin
                     partial_ff[row_ff[0]] <= lsum;
                     state_ff <= ST_IDLE;
                  end else begin
                     // view bookkeeping happens once per row-2 item
                     if (vnext >= limit) begin
                        vctr_ff <= '0;
                     end else begin
                        vctr_ff <= vnext[VCTR_W-1:0];
                     end
                     state_ff <= ST_SCL;
                  end
               end
            end
            ST_SCL: begin
               if (m_ff[63:31] == '0) begin
                  state_ff <= ST_NRM;
               end
            end
            ST_NRM: begin
               if (ma_ff == '0 && mb_ff == '0) begin
                  state_ff <= ST_OUT;
               end else if (ma_ff[31] || mb_ff[31] || ma_ff[30] || mb_ff[30]) begin
                  state_ff <= ST_SQ;
                  cnt_ff   <= '0;
               end
            end
            ST_SQ: begin
               if (cnt_ff[0]) begin
                  state_ff <= ST_ROOT;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            ST_ROOT: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_rsp[0].done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               row_ff     <= req_if.index[1:0];
               coef_ff[0] <= req_if.coef_0;
               coef_ff[1] <= req_if.coef_1;
               coef_ff[2] <= req_if.coef_2;
               coef_ff[3] <= req_if.coef_3;
               coef_ff[4] <= req_if.coef_4;
               coef_ff[5] <= req_if.coef_5;
               pt_ff[0]   <= req_if.first_x;
               pt_ff[1]   <= req_if.first_y;
               pt_ff[2]   <= req_if.second_x;
               pt_ff[3]   <= req_if.second_y;
            end
         end
         ST_PLK: begin
            sc_a_ff <= partial_ff[0];
            sc_b_ff <= partial_ff[1];
            sc_c_ff <= lsum;
            m_ff    <= m_in;
            last_ff <= vnext >= limit;
         end
         ST_SCL: begin
            // common floor shift until every magnitude sits below 2^31
            if (m_ff[63:31] != '0) begin
               m_ff    <= m_ff >> 1;
               sc_a_ff <= sc_a_ff >>> 1;
               sc_b_ff <= sc_b_ff >>> 1;
               sc_c_ff <= sc_c_ff >>> 1;
            end else begin
               ma_ff <= mag_a[31:0];
               mb_ff <= mag_b[31:0];
               e_ff  <= EXP_W'(FRAC_BITS);
            end
         end
         ST_NRM: begin
            if (ma_ff == '0 && mb_ff == '0) begin
               deg_ff <= 1'b1;
            end else if (ma_ff[31] || mb_ff[31]) begin
               ma_ff  <= ma_ff >> 1;
               mb_ff  <= mb_ff >> 1;
               e_ff   <= EXP_W'(FRAC_BITS - 1);
               deg_ff <= 1'b0;
            end else if (!(ma_ff[30] || mb_ff[30])) begin
               ma_ff <= ma_ff << 1;
               mb_ff <= mb_ff << 1;
               e_ff  <= e_ff + EXP_W'(1);
            end else begin
               deg_ff <= 1'b0;
            end
         end
         ST_SQ: begin
            if (!cnt_ff[0]) begin
               sq1_ff <= ma_ff * ma_ff;
               sq2_ff <= mb_ff * mb_ff;
               px1_ff <= a_q * pt_ff[0];
               py1_ff <= b_q * pt_ff[1];
               px2_ff <= a_q * pt_ff[2];
               py2_ff <= b_q * pt_ff[3];
            end else begin
               rad_ff    <= sq1_ff + sq2_ff;
               root_ff   <= '0;
               bit_ff    <= 64'd1 << 62;
               num_ff[0] <= (px1_ff >>> FRAC_BITS) + (py1_ff >>> FRAC_BITS) + sc_c_ff;
               num_ff[1] <= (px2_ff >>> FRAC_BITS) + (py2_ff >>> FRAC_BITS) + sc_c_ff;
            end
         end
         ST_ROOT: begin
            // one result bit per cycle
            if (rad_ff >= trial) begin
               rad_ff  <= rad_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               dist1_ff    <= deg_ff ? '0 : div_rsp[0].quo;
               dist2_ff    <= deg_ff ? '0 : div_rsp[1].quo;
               rsp_deg_ff  <= deg_ff;
               rsp_last_ff <= last_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.dist_first  = dist1_ff;
   assign rsp_if.dist_second = dist2_ff;
   assign rsp_if.degenerate  = rsp_deg_ff;
   assign rsp_if.last_view   = rsp_last_ff;

`ifndef SYNTHESIS
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_deg_ff |-> dist1_ff == '0 && dist2_ff == '0)
      else $error("degenerate result with nonzero distance");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp[0].done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_rsp[0].done == div_rsp[1].done)
      else $error("divider lanes out of step");
`endif
endmodule

>>> verif/line_reprojection_residual_tb.sv
// Testbench for the line reprojection residual block: random views checked by a scoreboard.
`timescale 1ns / 100ps

module line_reprojection_residual_tb import llr_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;

   typedef struct {
      bit               kind;
      bit [4:0]         idx;
      bit signed [31:0] coef [6];
      bit signed [31:0] fx, fy, sx, sy;
   } item_type;

   typedef struct {
      int d_first;
      int d_second;
      bit degen;
      bit last;
   } residual_type;

   // scoreboard: own copy of the block state, queue of expected residuals
   class residual_scoreboard;
      longint           lparam [4];
      int unsigned      vcount;
      int               words [STORE_DEPTH];
      longint           partial [2];
      int unsigned      vctr;
      longint           pt_a [4];
      longint           pt_b [4];
      longint           plk [6];
      residual_type     pending [$];
      int               errors;

      function new();
         foreach (lparam[i]) lparam[i] = 0;
         foreach (words[i]) words[i] = 0;
         vcount = 1;
         partial[0] = 0;
         partial[1] = 0;
         vctr = 0;
         errors = 0;
      endfunction

      function longint qm(longint a, longint b);
         return (a * b) >>> FRAC_BITS;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned mg(longint v);
         longint unsigned u;
         u = v;
         return v < 0 ? -u : u;
      endfunction

      function longint unsigned root(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // m * 2^e / n; returns 2^31 + 1 early once the running quotient passes 2^31
      function longint unsigned quot(longint unsigned m, longint unsigned n, int e);
         longint unsigned q, r;
         if (e < 0) begin
            m = m >> (-e);
            e = 0;
         end
         q = m / n;
         r = m % n;
         for (int i = 0; i < e; i++) begin
            if (q > 64'h8000_0000) return 64'h8000_0001;
            q = q << 1;
            r = r << 1;
            if (r >= n) begin
               q++;
               r = r - n;
            end
         end
         return q;
      endfunction

      function int distance_of(longint a, longint b, longint c, longint unsigned n, int e,
                               longint x, longint y);
         longint num;
         longint unsigned m;
         num = qm(a, x) + qm(b, y) + c;
         m = quot(mg(num), n, e);
         if (num < 0) return m >= 64'h8000_0000 ? 32'sh8000_0000 : -int'(m);
         return m >= 64'h8000_0000 ? 32'sh7FFF_FFFF : int'(m);
      endfunction

      function void points();
         for (int i = 0; i < 4; i++) begin
            pt_a[i] = sat(longint'(words[3*i]) + qm(lparam[0], words[3*i+1])
                          + qm(lparam[1], words[3*i+2]));
            pt_b[i] = sat(longint'(words[12+3*i]) + qm(lparam[2], words[12+3*i+1])
                          + qm(lparam[3], words[12+3*i+2]));
         end
         plk[0] = sat(qm(pt_a[1], pt_b[2]) - qm(pt_a[2], pt_b[1]));
         plk[1] = sat(qm(pt_a[2], pt_b[0]) - qm(pt_a[0], pt_b[2]));
         plk[2] = sat(qm(pt_a[0], pt_b[1]) - qm(pt_a[1], pt_b[0]));
         for (int i = 0; i < 3; i++)
            plk[3+i] = sat(qm(pt_b[3], pt_a[i]) - qm(pt_a[3], pt_b[i]));
      endfunction

      function void write_reg(int idx, bit [31:0] v);
         if (idx < 4) lparam[idx] = longint'(int'(v));
         else vcount = v & 32'h7FF;
      endfunction

      function void note(item_type it);
         longint l2, a, b, c;
         longint unsigned m, ma, mb, mx, n;
         int unsigned lim;
         int s, t;
         residual_type r;
         if (it.kind == REQ_LOAD) begin
            if (it.idx < STORE_DEPTH) words[it.idx] = it.coef[0];
            return;
         end
         if (it.idx > 2) return;
         points();
         l2 = 0;
         for (int j = 0; j < 6; j++) l2 += qm(plk[j], it.coef[j]);
         if (it.idx < 2) begin
            partial[it.idx] = l2;
            return;
         end
         lim = vcount == 0 ? 1 : (vcount > MAX_VIEWS ? MAX_VIEWS : vcount);
         r.last = (vctr + 1 >= lim);
         vctr = r.last ? 0 : ((vctr + 1) & 32'h3FF);
         // common floor shift brings l0, l1, l2 under 2^31
         m = mg(partial[0]);
         if (mg(partial[1]) > m) m = mg(partial[1]);
         if (mg(l2) > m) m = mg(l2);
         s = 0;
         while (m >= 64'h8000_0000) begin
            m = m >> 1;
            s++;
         end
         a = partial[0] >>> s;
         b = partial[1] >>> s;
         c = l2 >>> s;
         ma = mg(a);
         mb = mg(b);
         mx = ma > mb ? ma : mb;
         r.degen = 0;
         r.d_first = 0;
         r.d_second = 0;
         if (mx == 0) begin
            r.degen = 1;
         end else begin
            t = 0;
            if (mx >= 64'h8000_0000) begin
               ma = ma >> 1;
               mb = mb >> 1;
               t = -1;
            end else begin
               while (mx < 64'h4000_0000) begin
                  mx = mx << 1;
                  ma = ma << 1;
                  mb = mb << 1;
                  t++;
               end
            end
            n = root(ma * ma + mb * mb);
            r.d_first  = distance_of(a, b, c, n, FRAC_BITS + t, it.fx, it.fy);
            r.d_second = distance_of(a, b, c, n, FRAC_BITS + t, it.sx, it.sy);
         end
         pending.push_back(r);
      endfunction

      function void check(residual_type got);
         residual_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected residual d1=%0d d2=%0d", got.d_first,
                                       got.d_second);
            return;
         end
         want = pending.pop_front();
         if (got.d_first != want.d_first || got.d_second != want.d_second ||
             got.degen != want.degen || got.last != want.last) begin
            errors++;
            if (errors <= 10)
               $display({"residual mismatch: exp d1=%0d d2=%0d deg=%0b last=%0b,",
                         " got d1=%0d d2=%0d deg=%0b last=%0b"},
                        want.d_first, want.d_second, want.degen, want.last,
                        got.d_first, got.d_second, got.degen, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   llr_req_if req_if ();
   llr_rsp_if rsp_if ();

   line_reprojection_residual dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if.sink),
      .rsp_if      (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   residual_scoreboard sb = new();
   bit quiet = 0;       // when set, neither side idles
   int idle_cycles = 0;
   int sent = 0;

   always #4 clock = ~clock;

   // gap lengths: mostly none or short, now and then long
   function automatic int gap();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Q16.16 value: zero, small, full range or an extreme
   function automatic bit signed [31:0] rq();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh8000_0000;
         3, 4:    return $urandom;
         default: return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   // store words stay modest so most points avoid saturation
   function automatic bit signed [31:0] rword();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
   endfunction

   // result side: ready drops at random
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold = gap();
      end
   end

   // monitor: transfers sampled at the rising edge
   always @(posedge clock) begin
      item_type it;
      residual_type r;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            it.kind = req_if.req_type;
            it.idx  = req_if.index;
            it.coef[0] = req_if.coef_0;
            it.coef[1] = req_if.coef_1;
            it.coef[2] = req_if.coef_2;
            it.coef[3] = req_if.coef_3;
            it.coef[4] = req_if.coef_4;
            it.coef[5] = req_if.coef_5;
            it.fx = req_if.first_x;
            it.fy = req_if.first_y;
            it.sx = req_if.second_x;
            it.sy = req_if.second_y;
            sb.note(it);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            r.d_first  = rsp_if.dist_first;
            r.d_second = rsp_if.dist_second;
            r.degen    = rsp_if.degenerate;
            r.last     = rsp_if.last_view;
            sb.check(r);
         end
         // watchdog: any transfer or register write restarts the count
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // one item; entered and left at a falling edge
   task automatic send(item_type it);
      int g;
      g = gap();
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= it.kind;
      req_if.index    <= it.idx;
      req_if.coef_0   <= it.coef[0];
      req_if.coef_1   <= it.coef[1];
      req_if.coef_2   <= it.coef[2];
      req_if.coef_3   <= it.coef[3];
      req_if.coef_4   <= it.coef[4];
      req_if.coef_5   <= it.coef[5];
      req_if.first_x  <= it.fx;
      req_if.first_y  <= it.fy;
      req_if.second_x <= it.sx;
      req_if.second_y <= it.sy;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      if (!(it.kind == REQ_LOAD && it.idx >= STORE_DEPTH) && !(it.kind == REQ_ROW && it.idx > 2))
         sent++;
   endtask

   task automatic load(int idx, bit signed [31:0] w);
      item_type it;
      it.kind = REQ_LOAD;
      it.idx = 5'(idx);
      foreach (it.coef[j]) it.coef[j] = $urandom;
      it.coef[0] = w;
      it.fx = $urandom;
      it.fy = $urandom;
      it.sx = $urandom;
      it.sy = $urandom;
      send(it);
   endtask

   task automatic row(int idx, bit signed [31:0] cv, bit signed [31:0] pv, bit rand_all);
      item_type it;
      it.kind = REQ_ROW;
      it.idx = 5'(idx);
      foreach (it.coef[j]) it.coef[j] = rand_all ? rq() : cv;
      it.fx = rand_all ? rq() : pv;
      it.fy = rand_all ? rq() : -pv;
      it.sx = rand_all ? rq() : pv;
      it.sy = rand_all ? rq() : pv;
      send(it);
   endtask

   task automatic view();
      quiet = ($urandom_range(0, 7) == 0);
      for (int r = 0; r < 3; r++) row(r, 0, 0, 1);
   endtask

   // APB write: setup then access; written at the access edge
   task automatic csr_write(logic [2:0] reg_idx, bit [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(reg_idx) << 2;
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.write_reg(reg_idx, v);
   endtask

   // let the block drain before touching registers
   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(bit [31:0] p0, bit [31:0] p1, bit [31:0] p2, bit [31:0] p3,
                            bit [31:0] vc);
      drain();
      csr_write(REG_LINE_PARAM_0, p0);
      csr_write(REG_LINE_PARAM_1, p1);
      csr_write(REG_LINE_PARAM_2, p2);
      csr_write(REG_LINE_PARAM_3, p3);
      csr_write(REG_VIEW_COUNT, vc);
   endtask

   // mostly whole views; the rest stray rows, reloads and ignored items
   task automatic random_phase(int target);
      int p;
      while (sent < target) begin
         p = $urandom_range(0, 99);
         if (p < 70) view();
         else if (p < 80) load($urandom_range(0, STORE_DEPTH - 1), rword());
         else if (p < 90) row($urandom_range(0, 31), 0, 0, 1);
         else load($urandom_range(0, 31), rword());
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = REQ_LOAD;
      req_if.index = '0;
      req_if.coef_0 = '0;
      req_if.coef_1 = '0;
      req_if.coef_2 = '0;
      req_if.coef_3 = '0;
      req_if.coef_4 = '0;
      req_if.coef_5 = '0;
      req_if.first_x = '0;
      req_if.first_y = '0;
      req_if.second_x = '0;
      req_if.second_y = '0;
      rsp_if.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every store word written before any row reads it
      for (int i = 0; i < STORE_DEPTH; i++) load(i, rword());

      // directed: degenerate normal, extremes, ignored indexes, rows out of order
      row(0, 0, 0, 0);
      row(1, 0, 0, 0);
      row(2, 32'sh0001_0000, 32'sh0002_0000, 0);
      configure(32'sh0000_8000, -32'sh0001_0000, 32'sh0003_0000, 32'sh0000_4000, 3);
      row(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
      row(1, 32'sh8000_0000, 32'sh8000_0000, 0);
      row(2, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      row(3, 32'sh0001_0000, 0, 0);
      row(31, 32'sh0001_0000, 0, 0);
      load(24, 32'sh7FFF_FFFF);
      load(31, 32'sh8000_0000);
      row(2, 32'sh0001_0000, 32'sh0001_0000, 0);
      row(1, -32'sh0001_0000, 32'sh0000_0001, 0);
      row(2, 32'sh0000_0001, -32'sh0000_0001, 0);

      random_phase(400);
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1024);
      random_phase(650);
      configure($urandom_range(0, 32'h0004_0000), 0, $urandom, $urandom_range(0, 32'h0002_0000), 0);
      random_phase(900);
      configure($urandom, $urandom, $urandom, $urandom, 2047);
      random_phase(1100);
      configure(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
                $urandom_range(1, 5));
      random_phase(1300);

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
